// File: hw/rtl/ipcmb_pkg.sv
`default_nettype none
package ipcmb_pkg;

	// Default sizes of the channel table.
	localparam int NumChanDef    = 16;
	localparam int MsgBytesDef   = 32;
	localparam int TaskIdBitsDef = 8;

	// Request kinds.
	localparam logic [2:0] REQ_ALLOC  = 3'd0;
	localparam logic [2:0] REQ_FREE   = 3'd1;
	localparam logic [2:0] REQ_WRITE  = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_LIST   = 3'd4;
	localparam logic [2:0] REQ_STATUS = 3'd5;

	// Result status codes.
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_NONE_FREE = 4'd1;
	localparam logic [3:0] ST_UNKNOWN   = 4'd2;
	localparam logic [3:0] ST_SELF      = 4'd3;
	localparam logic [3:0] ST_BAD_CHAN  = 4'd4;
	localparam logic [3:0] ST_NOT_OWNER = 4'd5;
	localparam logic [3:0] ST_NOT_CONN  = 4'd6;
	localparam logic [3:0] ST_TOO_LONG  = 4'd7;
	localparam logic [3:0] ST_SMALL     = 4'd8;
	localparam logic [3:0] ST_TOO_MANY  = 4'd9;

	// One result item as held in the output register.
	typedef struct packed {
		logic [3:0] status;
		logic [7:0] channel_out;
		logic [7:0] byte_out;
		logic [6:0] count;
		logic       owner_flag;
		logic       connected_flag;
		logic       ready_write;
		logic       ready_read;
		logic       final_res;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/ipcmb_ram.sv
`default_nettype none
module ipcmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hw/rtl/ipc_mailbox_channel_table.sv
// Mailbox channel table for inter-task messaging.
// Requests enter on the in_valid/in_ready channel, one request per accept;
// results leave on the out_valid/out_ready channel, final_res marking the
// last result of a request. Requests are served one at a time.
// A request is taken in the idle state; the channel record is read from the
// table memory at that edge and the request completes in the execute state
// once the output register is free; this holds for write bytes, status, free
// and allocate. A read streams its message byte by byte through S_RD_A and
// S_RD_B via the registered read port of the message store. A list counts
// the connected channels, then lists them unless none or over the length.
// Allocation finds the lowest free channel from the in-use flags at once.
// Reset clears the in-use flags, message lengths and full flags and the
// write position; owner, partner and message bytes are undefined until
// written. A result waits in the output register while out_ready is low;
// the block stalls the request in progress until the register frees.
`default_nettype none
module ipc_mailbox_channel_table #(
	parameter int NUM_CHAN     = ipcmb_pkg::NumChanDef,
	parameter int MSG_BYTES    = ipcmb_pkg::MsgBytesDef,
	parameter int TASK_ID_BITS = ipcmb_pkg::TaskIdBitsDef
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] req_type,
	input  wire logic [7:0] requester,
	input  wire logic [7:0] partner,
	input  wire logic       partner_known,
	input  wire logic [7:0] channel,
	input  wire logic [7:0] length,
	input  wire logic [7:0] data,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [3:0]      status,
	output logic [7:0]      channel_out,
	output logic [7:0]      byte_out,
	output logic [6:0]      count,
	output logic            owner_flag,
	output logic            connected_flag,
	output logic            ready_write,
	output logic            ready_read,
	output logic            final_res
);
	import ipcmb_pkg::*;

	localparam int CW    = $clog2(NUM_CHAN);
	localparam int SW    = CW + 1;
	localparam int NSLOT = 2 * NUM_CHAN;
	localparam int LW    = $clog2(MSG_BYTES + 1);
	localparam int SA    = $clog2(NSLOT * MSG_BYTES);
	localparam int IW    = TASK_ID_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EX   = 3'd1;
	localparam logic [2:0] S_RD_A = 3'd2;
	localparam logic [2:0] S_RD_B = 3'd3;
	localparam logic [2:0] S_LS_A = 3'd4;
	localparam logic [2:0] S_LS_B = 3'd5;

	logic [2:0]      state_q;
	logic [2:0]      req_q;
	logic [IW-1:0]   who_q;
	logic [IW-1:0]   pid_q;
	logic            known_q;
	logic [7:0]      chan_q;
	logic [7:0]      len_q;
	logic [7:0]      data_q;
	logic            last_q;

	logic [NUM_CHAN-1:0] in_use_q;
	logic [LW-1:0]       mlen_q  [NSLOT];
	logic [NSLOT-1:0]    mfull_q;
	logic [LW-1:0]       wi_q;
	logic                wrej_q;

	logic [LW-1:0] n_q;
	logic [LW-1:0] byte_q;
	logic [SA-1:0] base_q;
	logic [CW-1:0] scan_q;
	logic          pass_q;
	logic [CW:0]   cnt_q;
	logic [CW:0]   k_q;

	result_t res_q;
	logic    out_valid_q;

	logic [15:0]     requester_ext;
	logic [15:0]     partner_ext;
	logic [2*IW-1:0] rec_rd;
	logic [IW-1:0]   rd_owner;
	logic [IW-1:0]   rd_partner;
	logic [7:0]      st_rd;

	logic          out_free;
	logic          list_st;
	logic [CW-1:0] ch_idx;
	logic          ch_ok;
	logic [CW-1:0] cur_idx;
	logic          cur_valid;
	logic          cur_own;
	logic          cur_conn;
	logic [SW-1:0] wr_slot;
	logic [SW-1:0] rd_slot;
	logic          found;
	logic [CW-1:0] free_idx;
	logic [CW-1:0] rec_raddr;
	logic          rec_we;
	logic          st_we;
	logic [SA-1:0] st_waddr;
	logic [SA-1:0] st_raddr;
	logic          wr_ok;
	logic          wr_store;
	logic [CW:0]   cnt_new;

	assign requester_ext = {8'd0, requester};
	assign partner_ext   = {8'd0, partner};
	assign rd_owner      = rec_rd[2*IW-1:IW];
	assign rd_partner    = rec_rd[IW-1:0];

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign list_st  = (state_q == S_LS_A) || (state_q == S_LS_B);
	assign ch_idx   = chan_q[CW-1:0];
	assign ch_ok    = chan_q < 8'(NUM_CHAN);

	// Ownership and connection of the channel under test.
	always_comb begin
		cur_idx   = list_st ? scan_q : ch_idx;
		cur_valid = list_st ? 1'b1 : ch_ok;
		cur_own   = cur_valid && in_use_q[cur_idx] && (rd_owner == who_q);
		cur_conn  = cur_valid && in_use_q[cur_idx] &&
		            ((rd_owner == who_q) || (rd_partner == who_q));
		wr_slot   = {ch_idx, ~cur_own};
		rd_slot   = {ch_idx, cur_own};
	end

	// Lowest free channel.
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int i = NUM_CHAN - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				found    = 1'b1;
				free_idx = CW'(i);
			end
		end
	end

	// Memory addressing and write enables.
	always_comb begin
		if (state_q == S_IDLE) begin
			rec_raddr = channel[CW-1:0];
		end else if (list_st) begin
			rec_raddr = scan_q;
		end else begin
			rec_raddr = ch_idx;
		end
		wr_ok    = !wrej_q && !(len_q > 8'(MSG_BYTES)) && cur_conn;
		wr_store = wr_ok && (8'(wi_q) < len_q) && (wi_q < LW'(MSG_BYTES));
		rec_we   = (state_q == S_EX) && out_free && (req_q == REQ_ALLOC) &&
		           (who_q != pid_q) && known_q && found;
		st_we    = (state_q == S_EX) && out_free && (req_q == REQ_WRITE) && wr_store;
		st_waddr = SA'(wr_slot) * SA'(MSG_BYTES) + SA'(wi_q);
		st_raddr = base_q + SA'(byte_q);
		cnt_new  = cnt_q + (CW+1)'(cur_conn);
	end

	ipcmb_ram #(.WIDTH(2 * IW), .DEPTH(NUM_CHAN)) u_rec_ram (
		.clk     (clk),
		.we      (rec_we),
		.waddr   (free_idx),
		.wdata   ({who_q, pid_q}),
		.raddr   (rec_raddr),
		.rdata_q (rec_rd)
	);

	ipcmb_ram #(.WIDTH(8), .DEPTH(NSLOT * MSG_BYTES)) u_msg_ram (
		.clk     (clk),
		.we      (st_we),
		.waddr   (st_waddr),
		.wdata   (data_q),
		.raddr   (st_raddr),
		.rdata_q (st_rd)
	);

	// Request sequencer, table flags and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_use_q    <= '0;
			mfull_q     <= '0;
			wi_q        <= '0;
			wrej_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NSLOT; i++) begin
				mlen_q[i] <= '0;
			end
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						who_q   <= requester_ext[IW-1:0];
						pid_q   <= partner_ext[IW-1:0];
						known_q <= partner_known;
						chan_q  <= channel;
						len_q   <= length;
						data_q  <= data;
						last_q  <= last;
						state_q <= S_EX;
					end
				end
				S_EX: begin
					if (out_free) begin
						res_q       <= '0;
						res_q.final_res <= 1'b1;
						state_q     <= S_IDLE;
						case (req_q)
							REQ_ALLOC: begin
								out_valid_q <= 1'b1;
								if (who_q == pid_q) begin
									res_q.status <= ST_SELF;
								end else if (!known_q) begin
									res_q.status <= ST_UNKNOWN;
								end else if (!found) begin
									res_q.status <= ST_NONE_FREE;
								end else begin
									in_use_q[free_idx]      <= 1'b1;
									mlen_q[{free_idx, 1'b0}] <= '0;
									mlen_q[{free_idx, 1'b1}] <= '0;
									mfull_q[{free_idx, 1'b0}] <= 1'b0;
									mfull_q[{free_idx, 1'b1}] <= 1'b0;
									res_q.status      <= ST_OK;
									res_q.channel_out <= 8'(free_idx);
								end
							end
							REQ_FREE: begin
								out_valid_q <= 1'b1;
								if (!ch_ok) begin
									res_q.status <= ST_BAD_CHAN;
								end else if (!cur_own) begin
									res_q.status <= ST_NOT_OWNER;
								end else begin
									in_use_q[ch_idx]       <= 1'b0;
									mlen_q[{ch_idx, 1'b0}]  <= '0;
									mlen_q[{ch_idx, 1'b1}]  <= '0;
									mfull_q[{ch_idx, 1'b0}] <= 1'b0;
									mfull_q[{ch_idx, 1'b1}] <= 1'b0;
									res_q.status      <= ST_OK;
									res_q.channel_out <= chan_q;
								end
							end
							REQ_WRITE: begin
								if (wrej_q) begin
									if (last_q) begin
										wrej_q <= 1'b0;
									end
								end else if (!wr_ok) begin
									wi_q         <= '0;
									wrej_q       <= !last_q;
									out_valid_q  <= 1'b1;
									res_q.status <= (len_q > 8'(MSG_BYTES)) ?
									                ST_TOO_LONG : ST_NOT_CONN;
								end else if (!last_q) begin
									if (wi_q < LW'(MSG_BYTES)) begin
										wi_q <= wi_q + 1'b1;
									end
								end else begin
									wi_q             <= '0;
									mlen_q[wr_slot]  <= len_q[LW-1:0];
									mfull_q[wr_slot] <= 1'b1;
									out_valid_q      <= 1'b1;
									res_q.status     <= ST_OK;
									res_q.count      <= 7'(len_q);
								end
							end
							REQ_READ: begin
								if (!cur_conn) begin
									out_valid_q  <= 1'b1;
									res_q.status <= ST_NOT_CONN;
								end else if (len_q < 8'(mlen_q[rd_slot])) begin
									out_valid_q  <= 1'b1;
									res_q.status <= ST_SMALL;
								end else begin
									mlen_q[rd_slot]  <= '0;
									mfull_q[rd_slot] <= 1'b0;
									if (mlen_q[rd_slot] == '0) begin
										out_valid_q  <= 1'b1;
										res_q.status <= ST_OK;
									end else begin
										n_q     <= mlen_q[rd_slot];
										byte_q  <= '0;
										base_q  <= SA'(rd_slot) * SA'(MSG_BYTES);
										state_q <= S_RD_A;
									end
								end
							end
							REQ_LIST: begin
								scan_q  <= '0;
								pass_q  <= 1'b0;
								cnt_q   <= '0;
								k_q     <= '0;
								state_q <= S_LS_A;
							end
							REQ_STATUS: begin
								out_valid_q <= 1'b1;
								if (!ch_ok) begin
									res_q.status <= ST_BAD_CHAN;
								end else begin
									res_q.status      <= ST_OK;
									res_q.channel_out <= chan_q;
									if (cur_conn) begin
										res_q.owner_flag     <= cur_own;
										res_q.connected_flag <= 1'b1;
										res_q.ready_write    <= !mfull_q[wr_slot];
										res_q.ready_read     <= mfull_q[rd_slot];
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_A: begin
					state_q <= S_RD_B;
				end
				S_RD_B: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						res_q           <= '0;
						res_q.status    <= ST_OK;
						res_q.byte_out  <= st_rd;
						res_q.count     <= 7'(n_q);
						res_q.final_res <= (byte_q + 1'b1 == n_q);
						byte_q          <= byte_q + 1'b1;
						state_q         <= (byte_q + 1'b1 == n_q) ? S_IDLE : S_RD_A;
					end
				end
				S_LS_A: begin
					state_q <= S_LS_B;
				end
				S_LS_B: begin
					if (out_free) begin
						state_q <= S_LS_A;
						scan_q  <= scan_q + 1'b1;
						res_q   <= '0;
						if (!pass_q) begin
							cnt_q <= cnt_new;
							if (scan_q == CW'(NUM_CHAN - 1)) begin
								scan_q <= '0;
								pass_q <= 1'b1;
								if (8'(cnt_new) > len_q) begin
									out_valid_q     <= 1'b1;
									res_q.status    <= ST_TOO_MANY;
									res_q.final_res <= 1'b1;
									state_q         <= S_IDLE;
								end else if (cnt_new == '0) begin
									out_valid_q     <= 1'b1;
									res_q.status    <= ST_OK;
									res_q.final_res <= 1'b1;
									state_q         <= S_IDLE;
								end
							end
						end else if (cur_conn) begin
							out_valid_q       <= 1'b1;
							res_q.status      <= ST_OK;
							res_q.channel_out <= 8'(scan_q);
							res_q.count       <= 7'(cnt_q);
							res_q.final_res   <= (k_q + 1'b1 == cnt_q);
							k_q               <= k_q + 1'b1;
							if (k_q + 1'b1 == cnt_q) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign channel_out    = res_q.channel_out;
	assign byte_out       = res_q.byte_out;
	assign count          = res_q.count;
	assign owner_flag     = res_q.owner_flag;
	assign connected_flag = res_q.connected_flag;
	assign ready_write    = res_q.ready_write;
	assign ready_read     = res_q.ready_read;
	assign final_res      = res_q.final_res;

	// The shared write position never passes the buffer size.
	a_wi_range: assert property (@(posedge clk) disable iff (!arst_n)
		wi_q <= LW'(MSG_BYTES))
		else $error("write position beyond buffer size");

	// A message being streamed never reads past its length.
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_B) |-> (byte_q < n_q))
		else $error("read stream past message length");

	// A pending result is not lost while the receiver stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("pending result dropped");

	// No new request enters while a list or read is in progress.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(list_st || state_q == S_RD_A || state_q == S_RD_B) |-> !in_ready)
		else $error("request taken while busy");

endmodule
`default_nettype wire
